[src/cbl_pkg.sv]
package cbl_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_DEST_X        = 3'd0,
		REG_DEST_Y        = 3'd1,
		REG_RECT_WIDTH    = 3'd2,
		REG_RECT_HEIGHT   = 3'd3,
		REG_SCREEN_WIDTH  = 3'd4,
		REG_SCREEN_HEIGHT = 3'd5
	} cfg_reg_t;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 11;
	localparam int PIX_W = 16;
	localparam int FB_IDX_W = 20;
	localparam int COLOR_W = 32;

	// entries in the queue between front and back
	localparam int QDEPTH = 4;

	localparam logic [7:0] ALPHA = 8'hFF;

	// rgb565 to xrgb8888, low bits filled by replicating the top bits
	function automatic logic [COLOR_W-1:0] widen565(input logic [PIX_W-1:0] p);
		logic [4:0] r5;
		logic [5:0] g6;
		logic [4:0] b5;
		r5 = p[15:11];
		g6 = p[10:5];
		b5 = p[4:0];
		return {ALPHA, r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
	endfunction

endpackage

[src/clipped_rgb565_blit_top.sv]
// on-screen items pass the queue, the product stage and the output register in turn
// throughput: one item per cycle while not stalled, set by the raster counter update
// in the front and the one multiply stage in the back; off-screen items give no result
// reset: raster counters, queue and output valid clear at once, configuration
// registers take their reset values; no clearing pass
module clipped_rgb565_blit_top #(
	parameter int MAX_DIM = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [cbl_pkg::PIX_W-1:0]          src_pixel,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [cbl_pkg::FB_IDX_W-1:0]       fb_index,
	output logic [cbl_pkg::COLOR_W-1:0]        color_xrgb,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cbl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cbl_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CW = $clog2(MAX_DIM);
	localparam int DW = CW + 1;
	localparam int QW = 2 * CW + cbl_pkg::PIX_W;
	localparam int XW = 13;
	localparam logic [XW-1:0] MAXD = XW'(MAX_DIM);
	localparam logic [XW-1:0] SW_RST = (390 > MAX_DIM) ? MAXD : XW'(390);
	localparam logic [XW-1:0] SH_RST = (450 > MAX_DIM) ? MAXD : XW'(450);

	logic signed [cbl_pkg::CFG_DATA_W-1:0] dest_x_q, dest_y_q;
	logic [DW-1:0] rw_q, rh_q, sw_q, sh_q;
	logic [XW-1:0] data_x, dim_lo1, dim_lo0;

	logic          push, q_full, q_valid, q_pop;
	logic [QW-1:0] push_data, q_data;

	// size clamping on the written value
	always_comb begin
		data_x  = XW'(cfg_data);
		dim_lo0 = (data_x > MAXD) ? MAXD : data_x;
		dim_lo1 = (data_x == '0) ? XW'(1) : dim_lo0;
	end

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q <= '0;
			dest_y_q <= '0;
			rw_q     <= DW'(1);
			rh_q     <= DW'(1);
			sw_q     <= DW'(SW_RST);
			sh_q     <= DW'(SH_RST);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cbl_pkg::REG_DEST_X:        dest_x_q <= $signed(cfg_data);
				cbl_pkg::REG_DEST_Y:        dest_y_q <= $signed(cfg_data);
				cbl_pkg::REG_RECT_WIDTH:    rw_q <= DW'(dim_lo1);
				cbl_pkg::REG_RECT_HEIGHT:   rh_q <= DW'(dim_lo1);
				cbl_pkg::REG_SCREEN_WIDTH:  sw_q <= DW'(dim_lo0);
				cbl_pkg::REG_SCREEN_HEIGHT: sh_q <= DW'(dim_lo0);
				default: begin
				end
			endcase
		end
	end

	cbl_front #(
		.CW(CW),
		.DW(DW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.src_pixel (src_pixel),
		.dest_x    (dest_x_q),
		.dest_y    (dest_y_q),
		.rw        (rw_q),
		.rh        (rh_q),
		.sw        (sw_q),
		.sh        (sh_q),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	cbl_queue #(
		.W(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_data  (q_data)
	);

	cbl_back #(
		.CW(CW),
		.DW(DW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.sw         (sw_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.fb_index   (fb_index),
		.color_xrgb (color_xrgb)
	);

endmodule

[src/cbl_front.sv]
module cbl_front #(
	parameter int CW = 10,
	parameter int DW = 11
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [cbl_pkg::PIX_W-1:0]       src_pixel,
	input  logic signed [cbl_pkg::CFG_DATA_W-1:0] dest_x,
	input  logic signed [cbl_pkg::CFG_DATA_W-1:0] dest_y,
	input  logic [DW-1:0]                   rw,
	input  logic [DW-1:0]                   rh,
	input  logic [DW-1:0]                   sw,
	input  logic [DW-1:0]                   sh,
	input  logic                            q_full,
	output logic                            push,
	output logic [2*CW+cbl_pkg::PIX_W-1:0]  push_data
);

	localparam int SXW = ((CW + 1 > cbl_pkg::CFG_DATA_W) ? CW + 1 : cbl_pkg::CFG_DATA_W) + 1;

	logic [CW-1:0] col_q, row_q;
	logic [CW-1:0] col_eff, row_eff;
	logic [DW-1:0] col_inc, row_inc;
	logic signed [SXW-1:0] sx, sy;
	logic on_screen;
	logic accept;

	// counters left beyond a new size wrap first
	always_comb begin
		col_eff = (DW'(col_q) >= rw) ? '0 : col_q;
		row_eff = (DW'(row_q) >= rh) ? '0 : row_q;
	end

	// screen position and clip test
	always_comb begin
		sx = $signed(SXW'(dest_x)) + $signed(SXW'(col_eff));
		sy = $signed(SXW'(dest_y)) + $signed(SXW'(row_eff));
		on_screen = (sx >= 0) && (sy >= 0)
			&& (sx < $signed(SXW'(sw))) && (sy < $signed(SXW'(sh)));
	end

	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign push      = accept && on_screen;
	assign push_data = {sx[CW-1:0], sy[CW-1:0], src_pixel};

	assign col_inc = DW'(col_eff) + DW'(1);
	assign row_inc = DW'(row_eff) + DW'(1);

	// raster position within the rectangle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_inc >= rw) begin
				col_q <= '0;
				row_q <= (row_inc >= rh) ? '0 : CW'(row_inc);
			end else begin
				col_q <= CW'(col_inc);
				row_q <= row_eff;
			end
		end
	end

endmodule

[src/cbl_queue.sv]
module cbl_queue #(
	parameter int W = 36
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	output logic         pop_valid,
	input  logic         pop,
	output logic [W-1:0] pop_data
);

	localparam int PW = (cbl_pkg::QDEPTH > 1) ? $clog2(cbl_pkg::QDEPTH) : 1;
	localparam int NW = $clog2(cbl_pkg::QDEPTH + 1);

	logic [W-1:0]  mem_q [cbl_pkg::QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_pop;

	assign full      = (count_q == NW'(cbl_pkg::QDEPTH));
	assign pop_valid = (count_q != '0);
	assign do_pop    = pop && pop_valid;
	assign pop_data  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(cbl_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(cbl_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

[src/cbl_back.sv]
module cbl_back #(
	parameter int CW = 10,
	parameter int DW = 11
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  logic [2*CW+cbl_pkg::PIX_W-1:0]    q_data,
	output logic                              q_pop,
	input  logic [DW-1:0]                     sw,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cbl_pkg::FB_IDX_W-1:0]      fb_index,
	output logic [cbl_pkg::COLOR_W-1:0]       color_xrgb
);

	localparam int PRW = CW + DW;
	localparam int IW = (PRW > cbl_pkg::FB_IDX_W) ? PRW : cbl_pkg::FB_IDX_W;

	logic [CW-1:0]  q_sx, q_sy;
	logic [cbl_pkg::PIX_W-1:0] q_pix;

	logic                      v_s1;
	logic [PRW-1:0]            prod_s1;
	logic [CW-1:0]             sx_s1;
	logic [cbl_pkg::PIX_W-1:0] pix_s1;

	logic                      v_s2;
	logic [IW-1:0]             sum;
	logic                      load_s2, load_s1;

	assign {q_sx, q_sy, q_pix} = q_data;

	// stage advance
	assign load_s2 = !v_s2 || !out_stall;
	assign load_s1 = !v_s1 || load_s2;
	assign q_pop   = q_valid && load_s1;

	assign sum = IW'(prod_s1) + IW'(sx_s1);

	assign out_valid = v_s2;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= q_valid;
			end
			if (load_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// row offset product
	always_ff @(posedge clk) begin
		if (q_pop) begin
			prod_s1 <= PRW'(q_sy) * PRW'(sw);
			sx_s1   <= q_sx;
			pix_s1  <= q_pix;
		end
	end

	// index add and color widening into the output register
	always_ff @(posedge clk) begin
		if (load_s2 && v_s1) begin
			fb_index   <= sum[cbl_pkg::FB_IDX_W-1:0];
			color_xrgb <= cbl_pkg::widen565(pix_s1);
		end
	end

endmodule

[tb/tb.sv]
module tb;

	localparam int BLIT_MAX = 1024;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RAND_ITEMS = 1050;
	localparam int SEG_ITEMS = 44;
	localparam int NPLAN = 44;

	typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} chk_kind_t;

	typedef struct packed {
		row_kind_t                      kind;
		cbl_pkg::cfg_reg_t              creg;
		logic [cbl_pkg::CFG_DATA_W-1:0] cdata;
		logic [cbl_pkg::PIX_W-1:0]      pix;
		chk_kind_t                      chk;
		logic [cbl_pkg::FB_IDX_W-1:0]   want_idx;
		logic [cbl_pkg::COLOR_W-1:0]    want_color;
	} plan_row_t;

	typedef struct {
		logic [cbl_pkg::FB_IDX_W-1:0] idx;
		logic [cbl_pkg::COLOR_W-1:0]  color;
	} fb_write_t;

	// directed rows: reset config, color extremes, clipping and size corners
	localparam plan_row_t PLAN [NPLAN] = '{
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h0000, CHK_GIVEN, 20'h0, 32'hFF000000},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'hFFFF, CHK_GIVEN, 20'h0, 32'hFFFFFFFF},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'hF800, CHK_GIVEN, 20'h0, 32'hFFFF0000},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h07E0, CHK_GIVEN, 20'h0, 32'hFF00FF00},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h001F, CHK_GIVEN, 20'h0, 32'hFF0000FF},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h8410, CHK_GIVEN, 20'h0, 32'hFF848284},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h0821, CHK_GIVEN, 20'h0, 32'hFF080408},
		'{ROW_CFG,   cbl_pkg::REG_DEST_X, 11'h7FF, 16'h0000, CHK_NONE,  20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_RECT_WIDTH, 11'h003, 16'h0000, CHK_NONE, 20'h0, 32'h0},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h1234, CHK_MODEL, 20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_RECT_WIDTH, 11'h000, 16'h0000, CHK_NONE, 20'h0, 32'h0},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'hABCD, CHK_MODEL, 20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_RECT_WIDTH, 11'h003, 16'h0000, CHK_NONE, 20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_RECT_HEIGHT, 11'h002, 16'h0000, CHK_NONE, 20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_DEST_Y, 11'h7FF, 16'h0000, CHK_NONE,  20'h0, 32'h0},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h0001, CHK_MODEL, 20'h0, 32'h0},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h0002, CHK_MODEL, 20'h0, 32'h0},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h0400, CHK_MODEL, 20'h0, 32'h0},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h8000, CHK_MODEL, 20'h0, 32'h0},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h3C0F, CHK_MODEL, 20'h0, 32'h0},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'hC3F0, CHK_MODEL, 20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_RECT_WIDTH, 11'h7FF, 16'h0000, CHK_NONE, 20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_RECT_HEIGHT, 11'h7FF, 16'h0000, CHK_NONE, 20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_SCREEN_WIDTH, 11'h7FF, 16'h0000, CHK_NONE, 20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_SCREEN_HEIGHT, 11'h7FF, 16'h0000, CHK_NONE, 20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_DEST_X, 11'h3FF, 16'h0000, CHK_NONE,  20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_DEST_Y, 11'h3FF, 16'h0000, CHK_NONE,  20'h0, 32'h0},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h5555, CHK_MODEL, 20'h0, 32'h0},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'hAAAA, CHK_MODEL, 20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_DEST_Y, 11'h400, 16'h0000, CHK_NONE,  20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_DEST_X, 11'h400, 16'h0000, CHK_NONE,  20'h0, 32'h0},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h0F0F, CHK_MODEL, 20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_DEST_X, 11'h000, 16'h0000, CHK_NONE,  20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_DEST_Y, 11'h000, 16'h0000, CHK_NONE,  20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_SCREEN_WIDTH, 11'h000, 16'h0000, CHK_NONE, 20'h0, 32'h0},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'hFFFF, CHK_NONE,  20'h0, 32'h0},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h0000, CHK_NONE,  20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_SCREEN_WIDTH, 11'h186, 16'h0000, CHK_NONE, 20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_SCREEN_HEIGHT, 11'h000, 16'h0000, CHK_NONE, 20'h0, 32'h0},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h4321, CHK_NONE,  20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_SCREEN_HEIGHT, 11'h1C2, 16'h0000, CHK_NONE, 20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_RECT_WIDTH, 11'h001, 16'h0000, CHK_NONE, 20'h0, 32'h0},
		'{ROW_CFG,   cbl_pkg::REG_RECT_HEIGHT, 11'h001, 16'h0000, CHK_NONE, 20'h0, 32'h0},
		'{ROW_PIXEL, cbl_pkg::REG_DEST_X, 11'h000, 16'h7BEF, CHK_MODEL, 20'h0, 32'h0}
	};

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [cbl_pkg::PIX_W-1:0]      src_pixel = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [cbl_pkg::FB_IDX_W-1:0]   fb_index;
	logic [cbl_pkg::COLOR_W-1:0]    color_xrgb;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [cbl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [cbl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// shadow of the blit registers and raster position
	logic signed [10:0] org_x = '0;
	logic signed [10:0] org_y = '0;
	logic [10:0] rect_w = 11'd1;
	logic [10:0] rect_h = 11'd1;
	logic [10:0] scr_w = 11'd390;
	logic [10:0] scr_h = 11'd450;
	logic [9:0]  col_pos = '0;
	logic [9:0]  row_pos = '0;

	fb_write_t pending_writes [$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int n_err = 0;
	int n_results = 0;
	int cycles = 0;

	clipped_rgb565_blit_top #(.MAX_DIM(BLIT_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.src_pixel(src_pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fb_index(fb_index),
		.color_xrgb(color_xrgb),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// random receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// compare each framebuffer write with the oldest prediction
	always @(posedge clk) begin : fb_check
		fb_write_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_writes.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected item: idx %0h color %08h", fb_index, color_xrgb);
			end else begin
				want = pending_writes.pop_front();
				if (fb_index !== want.idx || color_xrgb !== want.color) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: idx exp %0h got %0h, color exp %08h got %08h",
							want.idx, fb_index, want.color, color_xrgb);
				end
			end
		end
	end

	function automatic int clamp_dim(input logic [10:0] v, input int lo);
		if (int'(v) < lo)
			return lo;
		if (int'(v) > BLIT_MAX)
			return BLIT_MAX;
		return int'(v);
	endfunction

	function automatic logic [10:0] pick_rect_size();
		if ($urandom_range(0, 99) < 85)
			return 11'($urandom_range(1, 12));
		return 11'($urandom_range(0, 2047));
	endfunction

	function automatic logic [10:0] pick_screen_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 11'd0;
		if (r < 75)
			return 11'($urandom_range(1, 20));
		return 11'($urandom_range(0, 2047));
	endfunction

	// origin mostly near the screen edges so the rectangle gets clipped
	function automatic logic [10:0] pick_origin(input int rect, input int scr);
		int v;
		if ($urandom_range(0, 99) >= 75)
			return 11'($urandom_range(0, 2047));
		v = int'($urandom_range(0, scr + rect)) - rect;
		if (v > 1023)
			v = 1023;
		if (v < -1024)
			v = -1024;
		return v[10:0];
	endfunction

	// wait for all predicted writes, then let off-screen items leave the pipe
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// caller lowers cfg_valid after the last write of a batch
	task automatic write_reg(input cbl_pkg::cfg_reg_t r,
			input logic [cbl_pkg::CFG_DATA_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		case (r)
			cbl_pkg::REG_DEST_X:        org_x = v;
			cbl_pkg::REG_DEST_Y:        org_y = v;
			cbl_pkg::REG_RECT_WIDTH:    rect_w = v;
			cbl_pkg::REG_RECT_HEIGHT:   rect_h = v;
			cbl_pkg::REG_SCREEN_WIDTH:  scr_w = v;
			cbl_pkg::REG_SCREEN_HEIGHT: scr_h = v;
			default: ;
		endcase
	endtask

	// drive one pixel, predict its framebuffer write on acceptance
	task automatic send_pixel(input logic [cbl_pkg::PIX_W-1:0] pix, input chk_kind_t chk,
			input logic [cbl_pkg::FB_IDX_W-1:0] g_idx,
			input logic [cbl_pkg::COLOR_W-1:0] g_color);
		int rw, rh, sw, sh, c, r, sx, sy;
		logic [7:0] r8, g8, b8;
		logic [4:0] r5, b5;
		logic [5:0] g6;
		fb_write_t w;
		in_valid <= 1'b1;
		src_pixel <= pix;
		do @(posedge clk); while (in_stall);
		rw = clamp_dim(rect_w, 1);
		rh = clamp_dim(rect_h, 1);
		sw = clamp_dim(scr_w, 0);
		sh = clamp_dim(scr_h, 0);
		c = int'(col_pos);
		r = int'(row_pos);
		// position left past a shrunk rectangle wraps first
		if (c >= rw)
			c = 0;
		if (r >= rh)
			r = 0;
		sx = int'(org_x) + c;
		sy = int'(org_y) + r;
		r5 = pix[15:11];
		g6 = pix[10:5];
		b5 = pix[4:0];
		r8 = {r5, 3'b000} | {5'b0, r5[4:2]};
		g8 = {g6, 2'b00} | {6'b0, g6[5:4]};
		b8 = {b5, 3'b000} | {5'b0, b5[4:2]};
		w.idx = 20'(sy * sw + sx);
		w.color = {8'hFF, r8, g8, b8};
		if (chk == CHK_GIVEN) begin
			w.idx = g_idx;
			w.color = g_color;
			pending_writes.push_back(w);
		end else if (chk == CHK_MODEL && sx >= 0 && sy >= 0 && sx < sw && sy < sh) begin
			pending_writes.push_back(w);
		end
		// raster advance, also for clipped pixels
		c++;
		if (c >= rw) begin
			c = 0;
			r++;
			if (r >= rh)
				r = 0;
		end
		col_pos = 10'(c);
		row_pos = 10'(r);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
	endtask

	initial begin : stimulus
		int i, k, seg, n_sent;
		logic [10:0] rw, rh, sw, sh;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		send_idle_pct = 8;
		recv_stall_pct = 8;
		for (i = 0; i < NPLAN; i++) begin
			if (PLAN[i].kind == ROW_CFG) begin
				if (i == 0 || PLAN[i-1].kind != ROW_CFG)
					drain();
				write_reg(PLAN[i].creg, PLAN[i].cdata);
				if (i == NPLAN - 1 || PLAN[i+1].kind != ROW_CFG)
					cfg_valid <= 1'b0;
			end else begin
				send_pixel(PLAN[i].pix, PLAN[i].chk, PLAN[i].want_idx, PLAN[i].want_color);
			end
		end

		// random segments, each with its own geometry; the idling mode changes every third segment
		n_sent = 0;
		for (seg = 0; (n_sent < RAND_ITEMS || n_results < 60) && seg < 80; seg++) begin
			drain();
			case ((seg / 3) % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 69;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 69;
				end
				default: begin
					send_idle_pct = 8;
					recv_stall_pct = 8;
				end
			endcase
			rw = pick_rect_size();
			rh = pick_rect_size();
			sw = pick_screen_size();
			sh = pick_screen_size();
			write_reg(cbl_pkg::REG_DEST_X, pick_origin(clamp_dim(rw, 1), clamp_dim(sw, 0)));
			write_reg(cbl_pkg::REG_DEST_Y, pick_origin(clamp_dim(rh, 1), clamp_dim(sh, 0)));
			write_reg(cbl_pkg::REG_RECT_WIDTH, rw);
			write_reg(cbl_pkg::REG_RECT_HEIGHT, rh);
			write_reg(cbl_pkg::REG_SCREEN_WIDTH, sw);
			write_reg(cbl_pkg::REG_SCREEN_HEIGHT, sh);
			cfg_valid <= 1'b0;
			for (k = 0; k < SEG_ITEMS; k++) begin
				send_pixel(16'($urandom_range(0, 65535)), CHK_MODEL, '0, '0);
				n_sent++;
			end
		end

		drain();
		if (n_err == 0 && pending_writes.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
src/cbl_pkg.sv
src/cbl_front.sv
src/cbl_queue.sv
src/cbl_back.sv
src/clipped_rgb565_blit_top.sv
tb/tb.sv
